>>> sv/dersig_pkg.sv
// Shared types and constants for the lax DER signature parser.
`default_nettype none

package dersig_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned VALUE_W   = 256;
    localparam int unsigned LEN_ACC_W = 56;
    localparam int unsigned LBL_W     = 7;

    localparam logic [BYTE_W-1:0] SEQ_TAG = 8'h30;
    localparam logic [BYTE_W-1:0] INT_TAG = 8'h02;
    localparam int unsigned LONG_FORM_BIT = 7;

    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_SEQ_SKIP,
        PH_R_TAG,
        PH_R_LEN,
        PH_R_LENX,
        PH_R_VAL,
        PH_S_TAG,
        PH_S_LEN,
        PH_S_LENX,
        PH_S_VAL,
        PH_TAIL,
        PH_FAIL
    } phase_t;

    // Control from the parser to the value stores.
    typedef struct packed {
        logic step;
        logic last;
        logic shift_r;
        logic shift_s;
    } store_ctl_t;

    // Outcome of the signature after the current byte.
    typedef struct packed {
        logic ok;
        logic too_long;
    } status_t;

endpackage

`default_nettype wire

>>> sv/dersig_ctrl.sv
// Parser state machine: tags, length decoding and value byte counting.
`default_nettype none

module dersig_ctrl #(
    parameter int unsigned MAX_LENGTH_BYTES = 8,
    parameter int unsigned VALUE_BYTES      = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  step,
    input  wire logic                  last,
    output dersig_pkg::store_ctl_t     ctl,
    output dersig_pkg::status_t        status
);
    import dersig_pkg::*;

    localparam int unsigned LEN_CNT_W = $clog2(MAX_LENGTH_BYTES);
    localparam int unsigned LEN_CMP_W = LEN_CNT_W + 1;
    localparam int unsigned VAL_CNT_W = $clog2(VALUE_BYTES + 1);

    phase_t                 phase_reg, phase_next;
    logic [LBL_W-1:0]       lbl_reg, lbl_next;
    logic [LEN_ACC_W-1:0]   acc_reg, acc_next;
    logic [LEN_CNT_W-1:0]   sig_len_reg, sig_len_next;
    logic [LEN_ACC_W-1:0]   content_reg, content_next;
    logic [VAL_CNT_W-1:0]   sig_val_reg, sig_val_next;
    logic                   ovf_reg, ovf_next;

    logic                   is_s;
    phase_t                 after_int;
    logic [LEN_ACC_W-1:0]   acc_shift;
    logic [LEN_ACC_W-1:0]   len_value;
    logic [LEN_ACC_W-1:0]   content_dec;
    logic [LBL_W-1:0]       lbl_dec;
    logic                   len_full;
    logic                   val_room;
    logic                   lead_zero_len;
    logic                   lead_zero_val;
    logic                   shift;

    assign is_s          = phase_reg inside {PH_S_TAG, PH_S_LEN, PH_S_LENX, PH_S_VAL};
    assign after_int     = is_s ? PH_TAIL : PH_S_TAG;
    assign acc_shift     = {acc_reg[LEN_ACC_W-BYTE_W-1:0], data_byte};
    assign lead_zero_len = (sig_len_reg == '0) && (data_byte == '0);
    assign lead_zero_val = (sig_val_reg == '0) && (data_byte == '0);
    assign len_value     = lead_zero_len ? acc_reg : acc_shift;
    assign content_dec   = content_reg - LEN_ACC_W'(1);
    assign lbl_dec       = lbl_reg - LBL_W'(1);
    assign len_full      = (LEN_CMP_W'(sig_len_reg) + LEN_CMP_W'(1))
                           >= LEN_CMP_W'(MAX_LENGTH_BYTES);
    assign val_room      = sig_val_reg < VAL_CNT_W'(VALUE_BYTES);

    always_comb
    begin
        phase_next   = phase_reg;
        lbl_next     = lbl_reg;
        acc_next     = acc_reg;
        sig_len_next = sig_len_reg;
        content_next = content_reg;
        sig_val_next = sig_val_reg;
        ovf_next     = ovf_reg;
        shift        = 1'b0;

        case (phase_reg)
            PH_SEQ_TAG:
            begin
                phase_next = (data_byte == SEQ_TAG) ? PH_SEQ_LEN : PH_FAIL;
            end
            PH_SEQ_LEN:
            begin
                if (data_byte[LONG_FORM_BIT])
                begin
                    lbl_next   = data_byte[LBL_W-1:0];
                    phase_next = (data_byte[LBL_W-1:0] == '0) ? PH_R_TAG : PH_SEQ_SKIP;
                end
                else
                begin
                    phase_next = PH_R_TAG;
                end
            end
            PH_SEQ_SKIP:
            begin
                lbl_next = lbl_dec;
                if (lbl_dec == '0)
                begin
                    phase_next = PH_R_TAG;
                end
            end
            PH_R_TAG, PH_S_TAG:
            begin
                if (data_byte != INT_TAG)
                    phase_next = PH_FAIL;
                else
                    phase_next = is_s ? PH_S_LEN : PH_R_LEN;
            end
            PH_R_LEN, PH_S_LEN:
            begin
                sig_val_next = '0;
                if (data_byte[LONG_FORM_BIT])
                begin
                    lbl_next     = data_byte[LBL_W-1:0];
                    acc_next     = '0;
                    sig_len_next = '0;
                    if (data_byte[LBL_W-1:0] == '0)
                    begin
                        content_next = '0;
                        phase_next   = after_int;
                    end
                    else
                    begin
                        phase_next = is_s ? PH_S_LENX : PH_R_LENX;
                    end
                end
                else
                begin
                    content_next = LEN_ACC_W'(data_byte);
                    if (data_byte == '0)
                        phase_next = after_int;
                    else
                        phase_next = is_s ? PH_S_VAL : PH_R_VAL;
                end
            end
            PH_R_LENX, PH_S_LENX:
            begin
                if (!lead_zero_len && len_full)
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    if (!lead_zero_len)
                    begin
                        sig_len_next = sig_len_reg + LEN_CNT_W'(1);
                        acc_next     = acc_shift;
                    end
                    lbl_next = lbl_dec;
                    if (lbl_dec == '0)
                    begin
                        content_next = len_value;
                        sig_val_next = '0;
                        if (len_value == '0)
                            phase_next = after_int;
                        else
                            phase_next = is_s ? PH_S_VAL : PH_R_VAL;
                    end
                end
            end
            PH_R_VAL, PH_S_VAL:
            begin
                if (!lead_zero_val)
                begin
                    if (val_room)
                    begin
                        shift        = 1'b1;
                        sig_val_next = sig_val_reg + VAL_CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                content_next = content_dec;
                if (content_dec == '0)
                    phase_next = after_int;
            end
            PH_TAIL:
            begin
                phase_next = PH_TAIL;
            end
            default:
            begin
                phase_next = PH_FAIL;
            end
        endcase
    end

    assign ctl.step    = step;
    assign ctl.last    = last;
    assign ctl.shift_r = step && shift && !is_s;
    assign ctl.shift_s = step && shift && is_s;

    assign status.ok       = (phase_next == PH_TAIL);
    assign status.too_long = (phase_next == PH_TAIL) && ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEQ_TAG;
            lbl_reg     <= '0;
            acc_reg     <= '0;
            sig_len_reg <= '0;
            content_reg <= '0;
            sig_val_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg   <= PH_SEQ_TAG;
                lbl_reg     <= '0;
                acc_reg     <= '0;
                sig_len_reg <= '0;
                content_reg <= '0;
                sig_val_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                lbl_reg     <= lbl_next;
                acc_reg     <= acc_next;
                sig_len_reg <= sig_len_next;
                content_reg <= content_next;
                sig_val_reg <= sig_val_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/dersig_store.sv
// R and S value shift registers, one byte shifted in per significant byte.
`default_nettype none

module dersig_store (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [7:0]                        data_byte,
    input  wire dersig_pkg::store_ctl_t            ctl,
    output logic [dersig_pkg::VALUE_W-1:0]         r_value,
    output logic [dersig_pkg::VALUE_W-1:0]         s_value
);
    import dersig_pkg::*;

    logic [VALUE_W-1:0] r_store_reg;
    logic [VALUE_W-1:0] s_store_reg;

    // Values including the current byte, seen by the result register.
    assign r_value = ctl.shift_r ? {r_store_reg[VALUE_W-BYTE_W-1:0], data_byte} : r_store_reg;
    assign s_value = ctl.shift_s ? {s_store_reg[VALUE_W-BYTE_W-1:0], data_byte} : s_store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_store_reg <= '0;
            s_store_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.last)
            begin
                r_store_reg <= '0;
                s_store_reg <= '0;
            end
            else
            begin
                r_store_reg <= r_value;
                s_store_reg <= s_value;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/der_signature_lax_parser.sv
// Top level of the lax DER signature parser.
`default_nettype none

// Lax DER ECDSA signature parser. Bytes of one signature arrive on the item
// channel, the last one flagged by final_byte. The block checks the 0x30
// sequence tag, skips the sequence length (short or long form), then for R and
// S checks the 0x02 tag, decodes the length (leading zero length bytes in the
// long form are skipped; MAX_LENGTH_BYTES or more significant length bytes
// fail) and shifts the significant value bytes into a 256-bit value. Bytes
// after S are ignored. Exactly one result transfer follows each flagged byte:
// parse_ok, too_long and R/S as four 64-bit words each, word3 most
// significant. On failure everything is zero; on a value longer than
// VALUE_BYTES significant bytes too_long is set and both values are zero.
// No range check against a curve order is made.
// Rate: one byte per cycle, sustained unless a flagged byte waits. A byte
// transfer is registered in the input register; the parser logic then updates
// the state and, for a flagged byte, loads the result register, which raises
// result_valid. Only a flagged byte waits on a result still held in the
// output register; other bytes carry on meanwhile.
module der_signature_lax_parser #(
    parameter int unsigned MAX_LENGTH_BYTES = 8,
    parameter int unsigned VALUE_BYTES      = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire logic [7:0]     data_byte,
    input  wire logic           final_byte,
    output logic                result_valid,
    input  wire logic           result_ready,
    output logic                parse_ok,
    output logic                too_long,
    output logic [63:0]         r_word3,
    output logic [63:0]         r_word2,
    output logic [63:0]         r_word1,
    output logic [63:0]         r_word0,
    output logic [63:0]         s_word3,
    output logic [63:0]         s_word2,
    output logic [63:0]         s_word1,
    output logic [63:0]         s_word0
);
    import dersig_pkg::*;

    // Input register
    logic               in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;

    // Result register
    logic               res_vld_reg, res_vld_next;
    logic               ok_reg;
    logic               too_long_reg;
    logic [VALUE_W-1:0] r_reg;
    logic [VALUE_W-1:0] s_reg;

    logic               item_xfer;
    logic               advance;
    logic               load_result;
    logic               keep_value;
    store_ctl_t         ctl;
    status_t            status;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] s_value;

    // A byte moves on unless it is flagged and the result slot is occupied and not being taken.
    assign advance     = in_vld_reg && (!last_reg || !res_vld_reg || result_ready);
    assign item_ready  = !in_vld_reg || advance;
    assign item_xfer   = item_valid && item_ready;
    assign load_result = advance && last_reg;

    always_comb
    begin
        if (item_xfer)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_comb
    begin
        if (load_result)
            res_vld_next = 1'b1;
        else if (result_ready)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            byte_reg <= data_byte;
            last_reg <= final_byte;
        end
    end

    dersig_ctrl #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .VALUE_BYTES      (VALUE_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (byte_reg),
        .step      (advance),
        .last      (last_reg),
        .ctl       (ctl),
        .status    (status)
    );

    dersig_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (byte_reg),
        .ctl       (ctl),
        .r_value   (r_value),
        .s_value   (s_value)
    );

    // Values are only passed on for a clean parse without overflow.
    assign keep_value = status.ok && !status.too_long;

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            ok_reg       <= status.ok;
            too_long_reg <= status.too_long;
            r_reg        <= keep_value ? r_value : '0;
            s_reg        <= keep_value ? s_value : '0;
        end
    end

    assign result_valid = res_vld_reg;
    assign parse_ok     = ok_reg;
    assign too_long     = too_long_reg;
    assign r_word3      = r_reg[4*WORD_W-1:3*WORD_W];
    assign r_word2      = r_reg[3*WORD_W-1:2*WORD_W];
    assign r_word1      = r_reg[2*WORD_W-1:WORD_W];
    assign r_word0      = r_reg[WORD_W-1:0];
    assign s_word3      = s_reg[4*WORD_W-1:3*WORD_W];
    assign s_word2      = s_reg[3*WORD_W-1:2*WORD_W];
    assign s_word1      = s_reg[2*WORD_W-1:WORD_W];
    assign s_word0      = s_reg[WORD_W-1:0];

endmodule

`default_nettype wire
